@@ design/dcrv_pkg.sv @@
// Shared widths, codes and control structs for the running variance block.
// No dependencies; imported by the lane, square root and top-level modules.
package dcrv_pkg;

  localparam int DATA_W    = 16;
  localparam int LIMIT_W   = 15;
  localparam int FRAC_BITS = 7;
  localparam int MEAN_EXT  = 16;
  localparam int MEAN_W    = DATA_W + MEAN_EXT;
  localparam int DELTA_W   = MEAN_W + 1;
  localparam int MAG_W     = MEAN_W;
  localparam int PROD_W    = 2 * MAG_W;
  localparam int M2_W      = 48;
  localparam int ROOT_W    = M2_W / 2;
  localparam int SQ_REM_W  = ROOT_W + 2;
  localparam int CFG_IDX_W = 2;

  // Outlier limit after reset: 25 degrees
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(25 << FRAC_BITS);

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_FINISH = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_PITCH  = 2'd0,
    CFG_OFFSET_ROLL   = 2'd1,
    CFG_OUTLIER_LIMIT = 2'd2
  } cfg_reg_t;

  // Command from the sequencer to one channel lane
  typedef struct packed {
    logic clr;
    logic upd;
    logic fin;
  } lane_cmd_t;

  // Status from one channel lane back to the sequencer
  typedef struct packed {
    logic                     done;
    logic signed [MEAN_W-1:0] mean;
    logic [DATA_W-1:0]        dev;
  } lane_stat_t;

endpackage

@@ design/dual_channel_running_variance.sv @@
// Top level: input capture, differential angles, outlier and count checks,
// result register and configuration. Uses dcrv_pkg and two dcrv_lane.
//
//   channel  dir  handshake           beat contents
//   in_      in   in_valid/in_stall   func, head and vehicle pitch/roll
//   out_     out  out_valid/out_stall flags, count, means, deviations
//   cfg_     in   cfg_valid/cfg_ready register index and write data
//
// A counted sample passes through the lane's serial divider and multiplier before its
// result shows, and a finish also through the divider and square root (not at a count of
// at most one); a clear, no-op or other uncounted sample goes straight to the result
// register.
// Reset (rst_n low, synchronous) empties the accumulators and loads the register
// defaults. A stalled result holds while the next beat is taken; cfg_ready is high.
module dual_channel_running_variance
  import dcrv_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_func,
  input  logic [DATA_W-1:0]    in_hat_pitch,
  input  logic [DATA_W-1:0]    in_hat_roll,
  input  logic [DATA_W-1:0]    in_car_pitch,
  input  logic [DATA_W-1:0]    in_car_roll,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_accepted,
  output logic                 out_rejected_full,
  output logic [DATA_W-1:0]    out_sample_count,
  output logic [DATA_W-1:0]    out_mean_pitch,
  output logic [DATA_W-1:0]    out_mean_roll,
  output logic [DATA_W-1:0]    out_std_pitch,
  output logic [DATA_W-1:0]    out_std_roll,
  output logic                 out_finished,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_RESULT
  } seq_state_t;

  // head - vehicle - offset, saturated to the signed data range
  function automatic logic [DATA_W-1:0] diff_sat(input logic [DATA_W-1:0] hat,
                                                 input logic [DATA_W-1:0] car,
                                                 input logic [DATA_W-1:0] ofs);
    logic [DATA_W+1:0] d;
    d = {{2{hat[DATA_W-1]}}, hat} - {{2{car[DATA_W-1]}}, car}
        - {{2{ofs[DATA_W-1]}}, ofs};
    if (d[DATA_W+1:DATA_W-1] == 3'b000 || d[DATA_W+1:DATA_W-1] == 3'b111) begin
      return d[DATA_W-1:0];
    end else if (d[DATA_W+1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  // Drop the extra mean fraction bits, rounding half up
  function automatic logic [DATA_W-1:0] mean_round(input logic [MEAN_W-1:0] m);
    logic [MEAN_W-1:0] s;
    s = m + MEAN_W'(1 << (MEAN_EXT - 1));
    return s[MEAN_W-1:MEAN_EXT];
  endfunction

  seq_state_t            state_r, state_nxt;
  func_t                 func_r, func_nxt;
  logic [DATA_W-1:0]     hat_p_r, hat_p_nxt;
  logic [DATA_W-1:0]     hat_r_r, hat_r_nxt;
  logic [DATA_W-1:0]     car_p_r, car_p_nxt;
  logic [DATA_W-1:0]     car_r_r, car_r_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  acc_r, acc_nxt;
  logic                  full_r, full_nxt;
  logic                  fin_r, fin_nxt;
  logic                  done_p_r, done_p_nxt;
  logic                  done_q_r, done_q_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_acc_r, out_acc_nxt;
  logic                  out_full_r, out_full_nxt;
  logic [DATA_W-1:0]     out_cnt_r, out_cnt_nxt;
  logic [DATA_W-1:0]     out_mp_r, out_mp_nxt;
  logic [DATA_W-1:0]     out_mr_r, out_mr_nxt;
  logic [DATA_W-1:0]     out_sp_r, out_sp_nxt;
  logic [DATA_W-1:0]     out_sr_r, out_sr_nxt;
  logic                  out_fin_r, out_fin_nxt;

  logic [DATA_W-1:0]     ofs_p_r;
  logic [DATA_W-1:0]     ofs_r_r;
  logic [LIMIT_W-1:0]    limit_r;

  logic [DATA_W-1:0]     dp;
  logic [DATA_W-1:0]     dr;
  logic [DATA_W:0]       dp_ext;
  logic [DATA_W:0]       dp_mag;
  logic                  count_full;
  logic                  is_sample;
  logic                  take;
  logic                  out_load;
  lane_cmd_t             lane_cmd;
  lane_stat_t            stat_p;
  lane_stat_t            stat_q;

  dcrv_lane #(
    .COUNT_BITS (COUNT_BITS)
  ) u_lane_pitch (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (lane_cmd),
    .x     (dp),
    .n     (count_nxt),
    .stat  (stat_p)
  );

  dcrv_lane #(
    .COUNT_BITS (COUNT_BITS)
  ) u_lane_roll (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (lane_cmd),
    .x     (dr),
    .n     (count_nxt),
    .stat  (stat_q)
  );

  // Differential angles and the acceptance decision
  always_comb begin
    dp         = diff_sat(hat_p_r, car_p_r, ofs_p_r);
    dr         = diff_sat(hat_r_r, car_r_r, ofs_r_r);
    dp_ext     = {dp[DATA_W-1], dp};
    dp_mag     = dp_ext[DATA_W] ? (~dp_ext + (DATA_W+1)'(1)) : dp_ext;
    count_full = &count_r;
    is_sample  = (func_r == FUNC_SAMPLE) || (func_r == FUNC_FINISH);
    take       = is_sample && !count_full && (dp_mag <= (DATA_W+1)'(limit_r));
  end

  // Sequencer and result register
  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    hat_p_nxt     = hat_p_r;
    hat_r_nxt     = hat_r_r;
    car_p_nxt     = car_p_r;
    car_r_nxt     = car_r_r;
    count_nxt     = count_r;
    acc_nxt       = acc_r;
    full_nxt      = full_r;
    fin_nxt       = fin_r;
    done_p_nxt    = done_p_r;
    done_q_nxt    = done_q_r;
    out_acc_nxt   = out_acc_r;
    out_full_nxt  = out_full_r;
    out_cnt_nxt   = out_cnt_r;
    out_mp_nxt    = out_mp_r;
    out_mr_nxt    = out_mr_r;
    out_sp_nxt    = out_sp_r;
    out_sr_nxt    = out_sr_r;
    out_fin_nxt   = out_fin_r;
    lane_cmd      = '0;
    out_load      = (state_r == S_RESULT) && (!out_valid_r || !out_stall);
    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt  = func_t'(in_func);
          hat_p_nxt = in_hat_pitch;
          hat_r_nxt = in_hat_roll;
          car_p_nxt = in_car_pitch;
          car_r_nxt = in_car_roll;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        acc_nxt    = take;
        full_nxt   = is_sample && count_full;
        fin_nxt    = (func_r == FUNC_FINISH);
        done_p_nxt = 1'b0;
        done_q_nxt = 1'b0;
        state_nxt  = S_RESULT;
        unique case (func_r) inside
          FUNC_SAMPLE, FUNC_FINISH: begin
            if (take) begin
              count_nxt = count_r + COUNT_BITS'(1);
            end
            lane_cmd.upd = take;
            lane_cmd.fin = (func_r == FUNC_FINISH);
            if (take || (func_r == FUNC_FINISH)) begin
              state_nxt = S_WAIT;
            end
          end
          FUNC_CLEAR: begin
            count_nxt    = '0;
            lane_cmd.clr = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_WAIT: begin
        done_p_nxt = done_p_r || stat_p.done;
        done_q_nxt = done_q_r || stat_q.done;
        if ((done_p_r || stat_p.done) && (done_q_r || stat_q.done)) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_load) begin
          out_acc_nxt  = acc_r;
          out_full_nxt = full_r;
          out_cnt_nxt  = DATA_W'(count_r);
          out_mp_nxt   = mean_round(stat_p.mean);
          out_mr_nxt   = mean_round(stat_q.mean);
          out_sp_nxt   = fin_r ? stat_p.dev : '0;
          out_sr_nxt   = fin_r ? stat_q.dev : '0;
          out_fin_nxt  = fin_r;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      done_p_r    <= 1'b0;
      done_q_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      done_p_r    <= done_p_nxt;
      done_q_r    <= done_q_nxt;
      func_r      <= func_nxt;
      hat_p_r     <= hat_p_nxt;
      hat_r_r     <= hat_r_nxt;
      car_p_r     <= car_p_nxt;
      car_r_r     <= car_r_nxt;
      acc_r       <= acc_nxt;
      full_r      <= full_nxt;
      fin_r       <= fin_nxt;
      out_acc_r   <= out_acc_nxt;
      out_full_r  <= out_full_nxt;
      out_cnt_r   <= out_cnt_nxt;
      out_mp_r    <= out_mp_nxt;
      out_mr_r    <= out_mr_nxt;
      out_sp_r    <= out_sp_nxt;
      out_sr_r    <= out_sr_nxt;
      out_fin_r   <= out_fin_nxt;
    end
  end

  // Configuration writes; an unused index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_p_r <= '0;
      ofs_r_r <= '0;
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OFFSET_PITCH:  ofs_p_r <= cfg_data;
        CFG_OFFSET_ROLL:   ofs_r_r <= cfg_data;
        CFG_OUTLIER_LIMIT: limit_r <= cfg_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready         = 1'b1;
  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_accepted      = out_acc_r;
  assign out_rejected_full = out_full_r;
  assign out_sample_count  = out_cnt_r;
  assign out_mean_pitch    = out_mp_r;
  assign out_mean_roll     = out_mr_r;
  assign out_std_pitch     = out_sp_r;
  assign out_std_roll      = out_sr_r;
  assign out_finished      = out_fin_r;

endmodule

@@ design/dcrv_divider.sv @@
// Bit-serial restoring divider, one quotient bit per cycle, MSB first.
// Standalone; used by dcrv_lane for the mean step and the variance.
module dcrv_divider #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [$clog2(NUM_W+1)-1:0]   len,
  input  logic [NUM_W-1:0]             num,
  input  logic [DEN_W-1:0]             den,
  output logic                         done,
  output logic [NUM_W-1:0]             quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;

  // One restoring step: shift in the next numerator bit, try to subtract
  always_comb begin
    shifted  = {rem_r, quo_r[NUM_W-1]};
    diff     = shifted - {1'b0, den_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
      cnt_nxt  = len;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt = diff[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      den_r  <= den_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

@@ design/dcrv_sqrt.sv @@
// Digit-serial integer square root, two radicand bits per cycle.
// Depends on dcrv_pkg for the radicand and root widths.
module dcrv_sqrt
  import dcrv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [M2_W-1:0]   rad,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [M2_W-1:0]     rad_r, rad_nxt;
  logic [SQ_REM_W-1:0] rem_r, rem_nxt;
  logic [ROOT_W-1:0]   root_r, root_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [SQ_REM_W-1:0] rem_sh;
  logic [SQ_REM_W-1:0] trial;

  // Bring down the next digit and try the trial subtrahend 4r+1
  always_comb begin
    rem_sh   = {rem_r[SQ_REM_W-3:0], rad_r[M2_W-1 -: 2]};
    trial    = {root_r, 2'b01};
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = rad;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNT_W'(ROOT_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[M2_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

@@ design/dcrv_lane.sv @@
// One channel of the running statistics: mean and M2 accumulators, the
// Welford update and the deviation. Uses dcrv_pkg, dcrv_divider, dcrv_sqrt.
module dcrv_lane
  import dcrv_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lane_cmd_t               cmd,
  input  logic [DATA_W-1:0]       x,
  input  logic [COUNT_BITS-1:0]   n,
  output lane_stat_t              stat
);

  localparam int DIV_CNT_W = $clog2(M2_W + 1);
  localparam int MCNT_W    = $clog2(MAG_W);

  typedef enum logic [2:0] {
    L_IDLE,
    L_DIVM,
    L_AFT,
    L_MUL,
    L_M2,
    L_FIN,
    L_DIVV,
    L_SQRT
  } lane_state_t;

  lane_state_t           state_r, state_nxt;
  logic [MEAN_W-1:0]     mean_r, mean_nxt;
  logic [M2_W-1:0]       m2_r, m2_nxt;
  logic [DATA_W-1:0]     x_r, x_nxt;
  logic                  neg_r, neg_nxt;
  logic [MAG_W-1:0]      mag_r, mag_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [MCNT_W-1:0]     mcnt_r, mcnt_nxt;
  logic [COUNT_BITS-1:0] n_r, n_nxt;
  logic                  fin_r, fin_nxt;
  logic [DATA_W-1:0]     dev_r, dev_nxt;
  logic                  done_r, done_nxt;

  logic                  div_start;
  logic [DIV_CNT_W-1:0]  div_len;
  logic [M2_W-1:0]       div_num;
  logic [COUNT_BITS-1:0] div_den;
  logic                  div_done;
  logic [M2_W-1:0]       div_quo;
  logic                  sq_start;
  logic                  sq_done;
  logic [ROOT_W-1:0]     sq_root;

  logic [DATA_W-1:0]     x_sel;
  logic [MEAN_W-1:0]     xs;
  logic [DELTA_W-1:0]    delta;
  logic [DELTA_W-1:0]    delta_neg;
  logic [MAG_W-1:0]      delta_mag;
  logic [DELTA_W-1:0]    step_q;
  logic [DELTA_W-1:0]    mean_sum;
  logic [MAG_W:0]        msum;
  logic [MAG_W:0]        p_wide;
  logic [M2_W:0]         m2_sum;
  logic [M2_W-1:0]       m2_upd;

  dcrv_divider #(
    .NUM_W (M2_W),
    .DEN_W (COUNT_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .len   (div_len),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  dcrv_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .rad   (div_quo),
    .done  (sq_done),
    .root  (sq_root)
  );

  // Datapath: distance of the sample from the mean, mean step, M2 step
  always_comb begin
    x_sel     = (state_r == L_IDLE) ? x : x_r;
    xs        = {x_sel, {MEAN_EXT{1'b0}}};
    delta     = {xs[MEAN_W-1], xs} - {mean_r[MEAN_W-1], mean_r};
    delta_neg = ~delta + DELTA_W'(1);
    delta_mag = delta[DELTA_W-1] ? delta_neg[MAG_W-1:0] : delta[MAG_W-1:0];

    // Quotient is truncated toward zero, so apply the sign afterwards
    step_q    = {1'b0, div_quo[MAG_W-1:0]};
    if (neg_r) begin
      step_q = ~step_q + DELTA_W'(1);
    end
    mean_sum  = {mean_r[MEAN_W-1], mean_r} + step_q;

    // Shift-add multiply: add the multiplicand when the low bit is set
    msum      = {1'b0, prod_r[PROD_W-1:MAG_W]} + (prod_r[0] ? {1'b0, mag_r} : '0);

    // Round the product half up, then accumulate with saturation
    p_wide    = {1'b0, prod_r[PROD_W-1:MAG_W]} + {{MAG_W{1'b0}}, prod_r[MAG_W-1]};
    m2_sum    = {1'b0, m2_r} + (M2_W+1)'(p_wide[MAG_W-1:0]);
    m2_upd    = m2_sum[M2_W] ? '1 : m2_sum[M2_W-1:0];
  end

  // Sequencer for a clear, one update and optional deviation
  always_comb begin
    state_nxt = state_r;
    mean_nxt  = mean_r;
    m2_nxt    = m2_r;
    x_nxt     = x_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    prod_nxt  = prod_r;
    mcnt_nxt  = mcnt_r;
    n_nxt     = n_r;
    fin_nxt   = fin_r;
    dev_nxt   = dev_r;
    done_nxt  = 1'b0;
    div_start = 1'b0;
    div_len   = DIV_CNT_W'(MAG_W);
    div_num   = {delta_mag, {(M2_W-MAG_W){1'b0}}};
    div_den   = n;
    sq_start  = 1'b0;
    unique case (state_r)
      L_IDLE: begin
        if (cmd.clr) begin
          mean_nxt = '0;
          m2_nxt   = '0;
        end else if (cmd.upd) begin
          x_nxt     = x;
          neg_nxt   = delta[DELTA_W-1];
          mag_nxt   = delta_mag;
          n_nxt     = n;
          fin_nxt   = cmd.fin;
          div_start = 1'b1;
          state_nxt = L_DIVM;
        end else if (cmd.fin) begin
          n_nxt     = n;
          fin_nxt   = 1'b1;
          state_nxt = L_FIN;
        end
      end
      L_DIVM: begin
        if (div_done) begin
          mean_nxt  = mean_sum[MEAN_W-1:0];
          state_nxt = L_AFT;
        end
      end
      L_AFT: begin
        // Distance from the new mean is the multiplier
        prod_nxt  = {{MAG_W{1'b0}}, delta_mag};
        mcnt_nxt  = '0;
        state_nxt = L_MUL;
      end
      L_MUL: begin
        prod_nxt = {msum, prod_r[MAG_W-1:1]};
        mcnt_nxt = mcnt_r + MCNT_W'(1);
        if (mcnt_r == MCNT_W'(MAG_W - 1)) begin
          state_nxt = L_M2;
        end
      end
      L_M2: begin
        m2_nxt = m2_upd;
        if (fin_r) begin
          state_nxt = L_FIN;
        end else begin
          done_nxt  = 1'b1;
          state_nxt = L_IDLE;
        end
      end
      L_FIN: begin
        if (n_r <= COUNT_BITS'(1)) begin
          dev_nxt   = '0;
          done_nxt  = 1'b1;
          state_nxt = L_IDLE;
        end else begin
          div_start = 1'b1;
          div_len   = DIV_CNT_W'(M2_W);
          div_num   = m2_r;
          div_den   = n_r - COUNT_BITS'(1);
          state_nxt = L_DIVV;
        end
      end
      L_DIVV: begin
        if (div_done) begin
          sq_start  = 1'b1;
          state_nxt = L_SQRT;
        end
      end
      L_SQRT: begin
        if (sq_done) begin
          dev_nxt   = (|sq_root[ROOT_W-1:DATA_W]) ? '1 : sq_root[DATA_W-1:0];
          done_nxt  = 1'b1;
          state_nxt = L_IDLE;
        end
      end
      default: begin
        state_nxt = L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      mean_r  <= '0;
      m2_r    <= '0;
      done_r  <= 1'b0;
      dev_r   <= '0;
    end else begin
      state_r <= state_nxt;
      mean_r  <= mean_nxt;
      m2_r    <= m2_nxt;
      done_r  <= done_nxt;
      dev_r   <= dev_nxt;
      x_r     <= x_nxt;
      neg_r   <= neg_nxt;
      mag_r   <= mag_nxt;
      prod_r  <= prod_nxt;
      mcnt_r  <= mcnt_nxt;
      n_r     <= n_nxt;
      fin_r   <= fin_nxt;
    end
  end

  assign stat.done = done_r;
  assign stat.mean = mean_r;
  assign stat.dev  = dev_r;

endmodule

@@ design/dcrv_checker.sv @@
// Port-level checks for dual_channel_running_variance, bound to the top.
// No package dependency; sees only the top-level ports.
module dcrv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_accepted,
  input logic        out_rejected_full,
  input logic [15:0] out_sample_count,
  input logic [15:0] out_std_pitch,
  input logic [15:0] out_std_roll,
  input logic        out_finished
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_sample_count) && $stable(out_std_pitch)
      && $stable(out_std_roll) && $stable(out_finished))
    else $error("stalled result changed");

  // One item in flight: an accepted beat stalls the input next cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before the item finished");

  // Deviations only on a finish result
  a_dev_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_finished |-> (out_std_pitch == 16'd0) && (out_std_roll == 16'd0))
    else $error("deviation reported without finish");

  // A counted sample cannot also be rejected as full
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_accepted && out_rejected_full))
    else $error("accepted and rejected_full both set");

endmodule

bind dual_channel_running_variance dcrv_checker u_dcrv_checker (.*);

@@ test/testbench.sv @@
// Self-checking testbench for dual_channel_running_variance: directed and random
// angle beats, an in-bench prediction of the Welford statistics, and a field-by-field check.
// Depends on dcrv_pkg and the dual_channel_running_variance top level only.
`timescale 1ns / 1ps

module testbench;
  import dcrv_pkg::*;

  // Narrow counter so that the saturated-count behavior is reachable
  localparam int COUNT_BITS = 8;
  localparam longint unsigned COUNT_FULL = (64'd1 << COUNT_BITS) - 1;
  localparam logic [63:0] M2_SAT = (64'd1 << M2_W) - 1;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int PHASE_BEATS = 170;

  typedef struct {
    func_t              func;
    logic signed [15:0] hat_pitch;
    logic signed [15:0] hat_roll;
    logic signed [15:0] car_pitch;
    logic signed [15:0] car_roll;
  } angle_beat_t;

  typedef struct {
    logic        accepted;
    logic        rejected_full;
    logic [15:0] sample_count;
    logic [15:0] mean_pitch;
    logic [15:0] mean_roll;
    logic [15:0] std_pitch;
    logic [15:0] std_roll;
    logic        finished;
  } stats_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_func = FUNC_NOP;
  logic [DATA_W-1:0]    in_hat_pitch = '0;
  logic [DATA_W-1:0]    in_hat_roll = '0;
  logic [DATA_W-1:0]    in_car_pitch = '0;
  logic [DATA_W-1:0]    in_car_roll = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_accepted;
  logic                 out_rejected_full;
  logic [DATA_W-1:0]    out_sample_count;
  logic [DATA_W-1:0]    out_mean_pitch;
  logic [DATA_W-1:0]    out_mean_roll;
  logic [DATA_W-1:0]    out_std_pitch;
  logic [DATA_W-1:0]    out_std_roll;
  logic                 out_finished;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_OFFSET_PITCH;
  logic [DATA_W-1:0]    cfg_data = '0;

  // Beats waiting to be offered, and statistics waiting to come back
  angle_beat_t angle_pending[$];
  stats_beat_t stats_expected[$];
  angle_beat_t offered_beat;

  // Predicted register and accumulator state
  logic signed [15:0]  off_pitch = '0;
  logic signed [15:0]  off_roll = '0;
  logic [LIMIT_W-1:0]  limit = LIMIT_RESET;
  longint unsigned     n_samples = 0;
  longint              mean_p = 0;
  longint              mean_r = 0;
  longint unsigned     m2_p = 0;
  longint unsigned     m2_r = 0;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  logic rx_long_hold = 1'b0;
  logic long_hold_go = 1'b0;
  int mismatch_count = 0;
  int results_seen = 0;
  int beats_queued = 0;

  dual_channel_running_variance #(
    .COUNT_BITS(COUNT_BITS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_func(in_func),
    .in_hat_pitch(in_hat_pitch),
    .in_hat_roll(in_hat_roll),
    .in_car_pitch(in_car_pitch),
    .in_car_roll(in_car_roll),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_accepted(out_accepted),
    .out_rejected_full(out_rejected_full),
    .out_sample_count(out_sample_count),
    .out_mean_pitch(out_mean_pitch),
    .out_mean_roll(out_mean_roll),
    .out_std_pitch(out_std_pitch),
    .out_std_roll(out_std_roll),
    .out_finished(out_finished),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Differential angle with saturation to the signed 16-bit range
  function automatic longint diff_angle(logic signed [15:0] head, logic signed [15:0] car,
                                        logic signed [15:0] off);
    longint d;
    d = longint'(head) - longint'(car) - longint'(off);
    if (d > 32767) d = 32767;
    if (d < -32768) d = -32768;
    return d;
  endfunction

  // One Welford update: mean in Q.23, M2 in LSB^2, rounded half up, saturating
  function automatic void fold_sample(input longint x, input longint unsigned n,
                                      inout longint mean, inout longint unsigned m2);
    longint xs, delta, after;
    longint unsigned a, b, p;
    xs = x * 65536;
    delta = xs - mean;
    mean = mean + delta / longint'(n);
    after = xs - mean;
    a = (delta < 0) ? -delta : delta;
    b = (after < 0) ? -after : after;
    p = (a * b + 64'h8000_0000) >> 32;
    if (p > M2_SAT - m2) m2 = M2_SAT;
    else m2 = m2 + p;
  endfunction

  // Drop the extra fraction bits, round half up
  function automatic logic [15:0] mean_word(longint m);
    longint t;
    t = (m + 32768) >>> 16;
    return t[15:0];
  endfunction

  // Floor square root, two bits per step
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] std_word(longint unsigned m2, longint unsigned n);
    longint unsigned s;
    if (n <= 1) return 16'd0;
    s = root_floor(m2 / (n - 1));
    return (s > 65535) ? 16'hFFFF : s[15:0];
  endfunction

  // Advance the predicted state by one beat and return the statistics it yields
  function automatic stats_beat_t predict_stats(angle_beat_t b);
    stats_beat_t r;
    longint dp, dr, mag;
    r = '{default: '0};
    case (b.func)
      FUNC_CLEAR: begin
        n_samples = 0;
        mean_p = 0;
        mean_r = 0;
        m2_p = 0;
        m2_r = 0;
      end
      FUNC_SAMPLE, FUNC_FINISH: begin
        dp = diff_angle(b.hat_pitch, b.car_pitch, off_pitch);
        dr = diff_angle(b.hat_roll, b.car_roll, off_roll);
        mag = (dp < 0) ? -dp : dp;
        if (n_samples >= COUNT_FULL) begin
          r.rejected_full = 1'b1;
        end else if (mag <= longint'(limit)) begin
          n_samples = n_samples + 1;
          fold_sample(dp, n_samples, mean_p, m2_p);
          fold_sample(dr, n_samples, mean_r, m2_r);
          r.accepted = 1'b1;
        end
        if (b.func == FUNC_FINISH) begin
          r.finished = 1'b1;
          r.std_pitch = std_word(m2_p, n_samples);
          r.std_roll = std_word(m2_r, n_samples);
        end
      end
      default: ;
    endcase
    r.sample_count = n_samples[15:0];
    r.mean_pitch = mean_word(mean_p);
    r.mean_roll = mean_word(mean_r);
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    $display("%0t: %s mismatch in result %0d: got %0h expected %0h",
             $time, field, results_seen, got, want);
  endtask

  // Offer angle beats; predict each one as it is taken
  always @(posedge clk) begin : drive_angles
    angle_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) stats_expected.push_back(predict_stats(offered_beat));
      if (!in_valid || !in_stall) begin
        if (angle_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = angle_pending.pop_front();
          offered_beat <= nxt;
          in_valid <= 1'b1;
          in_func <= nxt.func;
          in_hat_pitch <= nxt.hat_pitch;
          in_hat_roll <= nxt.hat_roll;
          in_car_pitch <= nxt.car_pitch;
          in_car_roll <= nxt.car_roll;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Take result beats and compare them with the oldest prediction
  always @(posedge clk) begin : watch_stats
    stats_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (stats_expected.size() == 0) begin
        report_mismatch("unexpected result", 64'd1, 64'd0);
      end else begin
        want = stats_expected.pop_front();
        if (out_accepted !== want.accepted)
          report_mismatch("accepted", 64'(out_accepted), 64'(want.accepted));
        if (out_rejected_full !== want.rejected_full)
          report_mismatch("rejected_full", 64'(out_rejected_full), 64'(want.rejected_full));
        if (out_sample_count !== want.sample_count)
          report_mismatch("sample_count", 64'(out_sample_count), 64'(want.sample_count));
        if (out_mean_pitch !== want.mean_pitch)
          report_mismatch("mean_pitch", 64'(out_mean_pitch), 64'(want.mean_pitch));
        if (out_mean_roll !== want.mean_roll)
          report_mismatch("mean_roll", 64'(out_mean_roll), 64'(want.mean_roll));
        if (out_std_pitch !== want.std_pitch)
          report_mismatch("std_pitch", 64'(out_std_pitch), 64'(want.std_pitch));
        if (out_std_roll !== want.std_roll)
          report_mismatch("std_roll", 64'(out_std_roll), 64'(want.std_roll));
        if (out_finished !== want.finished)
          report_mismatch("finished", 64'(out_finished), 64'(want.finished));
      end
    end
    out_stall <= rst_n && (rx_long_hold || $urandom_range(99) < rx_stall_pct);
  end

  // Hold off the result channel for a long stretch once asked to
  initial begin : receiver_hold
    wait (long_hold_go);
    @(posedge clk);
    rx_long_hold <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    rx_long_hold <= 1'b0;
  end

  initial begin : watchdog
    #40_000_000;
    $display("dual_channel_running_variance verification failed");
    $finish;
  end

  // Head and vehicle angles whose difference minus offset is exactly d
  function automatic void angle_pair(input int off, input int d,
                                     output logic signed [15:0] head,
                                     output logic signed [15:0] car);
    int s, lo, hi, h;
    s = off + d;
    lo = (s > 0) ? -32768 + s : -32768;
    hi = (s < 0) ? 32767 + s : 32767;
    h = lo + int'($urandom_range(hi - lo));
    head = 16'(h);
    car = 16'(h - s);
  endfunction

  task automatic push_beat(func_t f, int hp, int hr, int cp, int cr);
    angle_beat_t b;
    b.func = f;
    b.hat_pitch = 16'(hp);
    b.hat_roll = 16'(hr);
    b.car_pitch = 16'(cp);
    b.car_roll = 16'(cr);
    angle_pending.push_back(b);
    beats_queued++;
  endtask

  // Beat with the given differential pitch and a random differential roll
  task automatic push_shaped(func_t f, int dp);
    angle_beat_t b;
    int dr;
    dr = $urandom_range(1) ? int'($urandom_range(4000)) - 2000
                           : int'($urandom_range(65534)) - 32767;
    b.func = f;
    angle_pair(int'(off_pitch), dp, b.hat_pitch, b.car_pitch);
    angle_pair(int'(off_roll), dr, b.hat_roll, b.car_roll);
    angle_pending.push_back(b);
    beats_queued++;
  endtask

  task automatic push_inlier(func_t f);
    int lim;
    lim = int'(limit);
    if ($urandom_range(9) == 0) push_shaped(f, $urandom_range(1) ? lim : -lim);
    else push_shaped(f, int'($urandom_range(2 * lim)) - lim);
  endtask

  task automatic push_noise(func_t f);
    push_beat(f, $urandom, $urandom, $urandom, $urandom);
  endtask

  // A run: optional clear, mostly in-range samples, then a finish
  task automatic queue_run(int len, bit start_clear);
    int k, lim, mag;
    lim = int'(limit);
    if (start_clear) push_noise(FUNC_CLEAR);
    for (int i = 0; i < len; i++) begin
      k = $urandom_range(99);
      if (k < 75) begin
        push_inlier(FUNC_SAMPLE);
      end else if (k < 85) begin
        push_noise($urandom_range(1) ? FUNC_FINISH : FUNC_SAMPLE);
      end else if (k < 93) begin
        push_noise(func_t'($urandom_range(3)));
      end else if (lim < 32767) begin
        mag = lim + 1 + int'($urandom_range(32766 - lim));
        push_shaped(FUNC_SAMPLE, $urandom_range(1) ? mag : -mag);
      end else begin
        push_beat(FUNC_SAMPLE, -32768, $urandom, $urandom_range(32767), $urandom);
      end
    end
    push_inlier(FUNC_FINISH);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (angle_pending.size() != 0 || in_valid || stats_expected.size() != 0);
  endtask

  // Write one register; track it in the predicted state on the handshake
  task automatic write_reg(cfg_reg_t idx, logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      CFG_OFFSET_PITCH: off_pitch = data;
      CFG_OFFSET_ROLL: off_roll = data;
      CFG_OUTLIER_LIMIT: limit = data[LIMIT_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : run_phases
    logic [15:0] cfg_set[4][3];
    int phase_start;
    cfg_set[0] = '{16'(int'($urandom_range(400)) - 200), 16'(int'($urandom_range(400)) - 200),
                   16'hFFFF};
    cfg_set[1] = '{16'h8000, 16'h7FFF, 16'h0000};
    cfg_set[2] = '{16'h7FFF, 16'h8000, 16'($urandom_range(32767))};
    cfg_set[3] = '{16'($urandom), 16'($urandom), 16'(LIMIT_RESET)};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed beats under the reset register values
    push_beat(FUNC_CLEAR, 0, 0, 0, 0);
    push_beat(FUNC_NOP, 0, 0, 0, 0);
    push_beat(FUNC_FINISH, 1000, 0, 0, 0);          // finish with a single sample
    push_beat(FUNC_FINISH, 0, 0, 0, 0);             // finish with two samples
    push_beat(FUNC_SAMPLE, 32767, 0, -32768, 0);    // pitch saturates high, outlier
    push_beat(FUNC_SAMPLE, -32768, 0, 32767, 0);    // pitch saturates low, outlier
    push_beat(FUNC_SAMPLE, 3200, 32767, 0, -32768); // on the limit, roll saturates high
    push_beat(FUNC_SAMPLE, 0, -32768, 3200, 32767); // on the limit, roll saturates low
    push_beat(FUNC_SAMPLE, 3201, 5, 0, 0);          // just past the limit
    push_beat(FUNC_SAMPLE, 0, 5, 3201, 0);
    push_beat(FUNC_SAMPLE, 32767, 32767, 32767, 32767);
    push_beat(FUNC_SAMPLE, -32768, -32768, -32768, -32768);
    push_beat(FUNC_FINISH, -1, 300, 0, 0);
    push_beat(FUNC_NOP, -1, -1, -1, -1);
    push_beat(FUNC_CLEAR, -1, -1, -1, -1);
    push_beat(FUNC_NOP, 0, 0, 0, 0);
    push_beat(FUNC_SAMPLE, 128, -640, 0, 0);
    push_beat(FUNC_SAMPLE, -256, 1280, 0, 0);
    push_beat(FUNC_SAMPLE, 2000, 100, -1000, 50);
    push_beat(FUNC_FINISH, -3000, -100, 0, 0);
    push_beat(FUNC_FINISH, 1, 1, 0, 0);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_OFFSET_PITCH, cfg_set[ph][0]);
      write_reg(CFG_OFFSET_ROLL, cfg_set[ph][1]);
      write_reg(CFG_OUTLIER_LIMIT, cfg_set[ph][2]);
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 49; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 49; end
        default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
      endcase
      phase_start = beats_queued;
      if (ph == 0) begin
        // Long run past the count limit while the receiver holds off
        queue_run(330, 1'b1);
        long_hold_go = 1'b1;
      end
      while (beats_queued - phase_start < PHASE_BEATS) begin
        queue_run($urandom_range(1, 30), $urandom_range(9) < 7);
        // now and then let the block run dry before the next run
        if ($urandom_range(5) == 0) wait_drained();
      end
      wait_drained();
    end

    repeat (300) @(negedge clk);
    if (mismatch_count == 0 && stats_expected.size() == 0) begin
      $display("dual_channel_running_variance verification clean");
    end else begin
      $display("dual_channel_running_variance verification failed");
    end
    $finish;
  end

endmodule
